[sv/mpeg_gop_keyframe_indexer_assert.svh]
// Assertion macros for the keyframe indexer checker
`ifndef MPEG_GOP_KEYFRAME_INDEXER_ASSERT_SVH
`define MPEG_GOP_KEYFRAME_INDEXER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define MGKI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mgki assertion failed");

// Next-cycle implication, checked on every rising edge out of reset
`define MGKI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mgki assertion failed");

`endif

[sv/mgki_pkg.sv]
// Shared constants, types and helpers of the GOP keyframe indexer
package mgki_pkg;

   // Widths fixed by the beat formats
   localparam int BYTE_BITS     = 8;
   localparam int WINDOW_BITS   = 24;
   localparam int GOP_SIZE_BITS = 8;
   localparam int GROUP_BITS    = 32;
   localparam int POS_BITS      = 48;
   localparam int FRAME_BITS    = 40;
   localparam int UNSAVED_BITS  = 5;
   localparam int WIDE_BITS     = 64;

   // Default width of the stream byte offset
   localparam int OFFSET_BITS_DEFAULT = 48;

   // Start code window and codes
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 24'hFFFFFF;
   localparam logic [WINDOW_BITS-1:0] CODE_PREFIX  = 24'h000001;
   localparam logic [BYTE_BITS-1:0]   CODE_PACK    = 8'hBA;
   localparam logic [BYTE_BITS-1:0]   CODE_GOP     = 8'hB8;
   localparam logic [BYTE_BITS-1:0]   CODE_SEQ     = 8'hB3;

   // A pack header's offset points at its first prefix byte
   localparam int PACK_BACKSTEP = 3;

   // Save-map rule
   localparam int EARLY_LIMIT = 30;
   localparam int FLUSH_LIMIT = 30;

   localparam logic [GOP_SIZE_BITS-1:0] GOP_SIZE_RESET = 8'd15;

   // Scanner status towards the indexer
   typedef struct packed {
      logic valid;     // a byte is waiting in the input register
      logic keyframe;  // that byte closes a GOP start code that counts
   } scan_type;

   // Early-save table: true for values below 30 that are one more than a multiple of five
   function automatic logic mod5_is_one(input logic [UNSAVED_BITS-1:0] v);
      logic r;
      unique case (v)
         5'd1, 5'd6, 5'd11, 5'd16, 5'd21, 5'd26: r = 1'b1;
         default:                                r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

[sv/mgki_scan.sv]
// Input register, start code window and stream offset tracking
module mgki_scan #(
   parameter int OFFSET_BITS = mgki_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [mgki_pkg::BYTE_BITS-1:0]     req_data_byte,
   input  logic                               advance,
   output mgki_pkg::scan_type                 scan,
   output logic [OFFSET_BITS-1:0]             pack_offset
);

   logic                                 in_valid_ff, in_valid_in;
   logic [mgki_pkg::BYTE_BITS-1:0]       byte_ff, byte_in;
   logic [mgki_pkg::WINDOW_BITS-1:0]     window_ff, window_in;
   logic [OFFSET_BITS-1:0]               offset_ff, offset_in;
   logic [OFFSET_BITS-1:0]               pack_ff, pack_in;
   logic [OFFSET_BITS-1:0]               seq_ff, seq_in;
   logic                                 prefix;

   assign prefix      = (window_ff == mgki_pkg::CODE_PREFIX);
   assign req_stall   = in_valid_ff && !advance;
   assign pack_offset = pack_ff;

   assign scan.valid    = in_valid_ff;
   assign scan.keyframe = in_valid_ff && prefix && (byte_ff == mgki_pkg::CODE_GOP)
                          && (seq_ff == pack_ff);

   // Input register: refills whenever the held byte moves on or none is held
   always_comb begin
      in_valid_in = in_valid_ff;
      byte_in     = byte_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         byte_in     = req_data_byte;
      end
   end

   // Window and offsets advance once per processed byte
   always_comb begin
      window_in = window_ff;
      offset_in = offset_ff;
      pack_in   = pack_ff;
      seq_in    = seq_ff;
      if (advance) begin
         window_in = {window_ff[mgki_pkg::WINDOW_BITS-mgki_pkg::BYTE_BITS-1:0], byte_ff};
         offset_in = offset_ff + OFFSET_BITS'(1);
         if (prefix) begin
            unique case (byte_ff)
               mgki_pkg::CODE_PACK: pack_in = offset_ff - OFFSET_BITS'(mgki_pkg::PACK_BACKSTEP);
               mgki_pkg::CODE_SEQ:  seq_in  = pack_ff;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         window_ff   <= mgki_pkg::WINDOW_RESET;
         offset_ff   <= '0;
         pack_ff     <= '0;
         seq_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         window_ff   <= window_in;
         offset_ff   <= offset_in;
         pack_ff     <= pack_in;
         seq_ff      <= seq_in;
      end
   end

   // Data byte needs no reset
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

[sv/mgki_index.sv]
// Keyframe counter, save-map rule and result register
module mgki_index #(
   parameter int OFFSET_BITS = mgki_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mgki_pkg::scan_type                   scan,
   input  logic                                 advance,
   input  logic [OFFSET_BITS-1:0]               pack_offset,
   input  logic [mgki_pkg::GOP_SIZE_BITS-1:0]   gop_size,
   output logic                                 res_free,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mgki_pkg::GROUP_BITS-1:0]      rsp_gop_number,
   output logic [mgki_pkg::POS_BITS-1:0]        rsp_pack_position,
   output logic [mgki_pkg::FRAME_BITS-1:0]      rsp_frame_count,
   output logic                                 rsp_flush
);

   logic                                 load;
   logic [mgki_pkg::GROUP_BITS-1:0]      group_ff, group_in, group_next;
   logic [mgki_pkg::UNSAVED_BITS-1:0]    unsaved_ff, unsaved_in;
   logic [mgki_pkg::UNSAVED_BITS:0]      unsaved_next;
   logic                                 save;
   logic [mgki_pkg::WIDE_BITS-1:0]       pack_wide;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [mgki_pkg::GROUP_BITS-1:0]      gop_number_ff, gop_number_in;
   logic [mgki_pkg::POS_BITS-1:0]        position_ff, position_in;
   logic [mgki_pkg::FRAME_BITS-1:0]      frames_ff, frames_in;
   logic                                 save_ff, save_in;

   assign res_free = !rsp_valid_ff || !rsp_stall;
   assign load     = advance && scan.keyframe;

   // Save rule on the incremented counters
   assign group_next   = group_ff + mgki_pkg::GROUP_BITS'(1);
   assign unsaved_next = {1'b0, unsaved_ff} + (mgki_pkg::UNSAVED_BITS + 1)'(1);
   assign save = ((group_next < mgki_pkg::GROUP_BITS'(mgki_pkg::EARLY_LIMIT))
                  && mgki_pkg::mod5_is_one(group_next[mgki_pkg::UNSAVED_BITS-1:0]))
                 || (unsaved_next >= (mgki_pkg::UNSAVED_BITS + 1)'(mgki_pkg::FLUSH_LIMIT));

   assign pack_wide = mgki_pkg::WIDE_BITS'(pack_offset);

   // Counters step on each keyframe
   always_comb begin
      group_in   = group_ff;
      unsaved_in = unsaved_ff;
      if (load) begin
         group_in   = group_next;
         unsaved_in = save ? '0 : unsaved_next[mgki_pkg::UNSAVED_BITS-1:0];
      end
   end

   // Result register: loads a keyframe, drains when taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      gop_number_in = gop_number_ff;
      position_in   = position_ff;
      frames_in     = frames_ff;
      save_in       = save_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         gop_number_in = group_next;
         position_in   = pack_wide[mgki_pkg::POS_BITS-1:0];
         frames_in     = mgki_pkg::FRAME_BITS'(group_ff)
                         * mgki_pkg::FRAME_BITS'(gop_size);
         save_in       = save;
      end else if (!rsp_stall) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff     <= '0;
         unsaved_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         group_ff     <= group_in;
         unsaved_ff   <= unsaved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gop_number_ff <= gop_number_in;
      position_ff   <= position_in;
      frames_ff     <= frames_in;
      save_ff       <= save_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_gop_number    = gop_number_ff;
   assign rsp_pack_position = position_ff;
   assign rsp_frame_count   = frames_ff;
   assign rsp_flush         = save_ff;

endmodule

[sv/mpeg_gop_keyframe_indexer.sv]
// Top level of the MPEG GOP keyframe indexer
//
//   channel  direction  handshake          payload
//   req_     in         valid / stall      data_byte
//   rsp_     out        valid / stall      gop_number, pack_position, frame_count, flush
//   csr_     in         valid / ready      gop_size
//
// One byte per clock unless a keyframe waits on a stalled result: a byte is
// held in the input register and its keyframe result appears in the result
// register on the edge that moves the byte on; the offset and counter updates are
// a single pass of adder and 32x8 multiply between these registers.
// Synchronous reset sets the window to all ones, clears offsets and counters, and sets gop_size to 15.
// A waiting result stalls the input only when the held byte is itself a keyframe.
module mpeg_gop_keyframe_indexer #(
   parameter int OFFSET_BITS = mgki_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mgki_pkg::BYTE_BITS-1:0]       req_data_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mgki_pkg::GROUP_BITS-1:0]      rsp_gop_number,
   output logic [mgki_pkg::POS_BITS-1:0]        rsp_pack_position,
   output logic [mgki_pkg::FRAME_BITS-1:0]      rsp_frame_count,
   output logic                                 rsp_flush,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mgki_pkg::GOP_SIZE_BITS-1:0]   csr_gop_size
);

   mgki_pkg::scan_type                   scan;
   logic [OFFSET_BITS-1:0]               pack_offset;
   logic                                 res_free;
   logic                                 advance;
   logic [mgki_pkg::GOP_SIZE_BITS-1:0]   gop_size_ff, gop_size_in;

   // A held byte moves on unless its result has nowhere to go
   assign advance = scan.valid && (!scan.keyframe || res_free);

   // GOP size register, always writable
   assign csr_ready   = 1'b1;
   assign gop_size_in = (csr_valid && csr_ready) ? csr_gop_size : gop_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gop_size_ff <= mgki_pkg::GOP_SIZE_RESET;
      end else begin
         gop_size_ff <= gop_size_in;
      end
   end

   mgki_scan #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .advance       (advance),
      .scan          (scan),
      .pack_offset   (pack_offset)
   );

   mgki_index #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_index (
      .clock             (clock),
      .reset             (reset),
      .scan              (scan),
      .advance           (advance),
      .pack_offset       (pack_offset),
      .gop_size          (gop_size_ff),
      .res_free          (res_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_gop_number    (rsp_gop_number),
      .rsp_pack_position (rsp_pack_position),
      .rsp_frame_count   (rsp_frame_count),
      .rsp_flush         (rsp_flush)
   );

endmodule

[sv/mgki_checker.sv]
// Port-level checker for the keyframe indexer, bound to the top level
`include "mpeg_gop_keyframe_indexer_assert.svh"

module mgki_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [mgki_pkg::GROUP_BITS-1:0]      rsp_gop_number,
   input logic [mgki_pkg::POS_BITS-1:0]        rsp_pack_position,
   input logic [mgki_pkg::FRAME_BITS-1:0]      rsp_frame_count,
   input logic                                 rsp_flush
);

   logic [mgki_pkg::GROUP_BITS+mgki_pkg::POS_BITS+mgki_pkg::FRAME_BITS:0] rsp_payload;
   logic                                 rsp_beat;
   logic                                 rsp_held;
   logic                                 early_entry;
   logic [mgki_pkg::GROUP_BITS-1:0]      succ_ff, succ_in;

   assign rsp_payload = {rsp_gop_number, rsp_pack_position, rsp_frame_count, rsp_flush};
   assign rsp_beat    = rsp_valid && !rsp_stall;
   assign rsp_held    = rsp_valid && rsp_stall;
   assign early_entry = (rsp_gop_number < mgki_pkg::GROUP_BITS'(mgki_pkg::EARLY_LIMIT))
                        && mgki_pkg::mod5_is_one(rsp_gop_number[mgki_pkg::UNSAVED_BITS-1:0]);

   // Number the next beat should carry
   assign succ_in = rsp_gop_number + mgki_pkg::GROUP_BITS'(1);

   always_ff @(posedge clock) begin
      succ_ff <= succ_in;
   end

   // A stalled result beat holds
   `MGKI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_payload))

   // Input only backs up behind a blocked result
   `MGKI_ASSERT_NOW(a_req_backpressure, clock, reset, req_stall, rsp_held)

   // Consecutive keyframes number one apart
   `MGKI_ASSERT_NEXT(a_gop_step, clock, reset, rsp_beat, !rsp_valid || rsp_gop_number == succ_ff)

   // Early entries one past a multiple of five always save
   `MGKI_ASSERT_NOW(a_early_save, clock, reset, rsp_valid && early_entry, rsp_flush)

endmodule

bind mpeg_gop_keyframe_indexer mgki_checker u_checker (.*);

[tb/tb_mpeg_gop_keyframe_indexer.sv]
// Self-checking testbench for the MPEG GOP keyframe indexer

// One keyframe beat as it leaves the block
typedef struct packed {
   logic [mgki_pkg::GROUP_BITS-1:0] gop_number;
   logic [mgki_pkg::POS_BITS-1:0]   pack_position;
   logic [mgki_pkg::FRAME_BITS-1:0] frame_count;
   logic                            flush;
} keyframe_type;

// Tracks the stream, predicts keyframe beats and checks them in order
class keyframe_scoreboard;
   localparam int EARLY_PERIOD = 5;

   logic [mgki_pkg::WINDOW_BITS-1:0]         window;
   logic [mgki_pkg::OFFSET_BITS_DEFAULT-1:0] stream_offset;
   logic [mgki_pkg::OFFSET_BITS_DEFAULT-1:0] pack_offset;
   logic [mgki_pkg::OFFSET_BITS_DEFAULT-1:0] seq_offset;
   logic [mgki_pkg::GROUP_BITS-1:0]          groups;
   logic [mgki_pkg::UNSAVED_BITS-1:0]        unsaved;
   logic [mgki_pkg::GOP_SIZE_BITS-1:0]       gop_size;
   keyframe_type                             expected_keyframes[$];
   int                                       errors;

   function new();
      window        = mgki_pkg::WINDOW_RESET;
      stream_offset = '0;
      pack_offset   = '0;
      seq_offset    = '0;
      groups        = '0;
      unsaved       = '0;
      gop_size      = mgki_pkg::GOP_SIZE_RESET;
      errors        = 0;
   endfunction

   function void set_gop_size(input logic [mgki_pkg::GOP_SIZE_BITS-1:0] v);
      gop_size = v;
   endfunction

   // Advance the scanner by one accepted byte
   function void note_byte(input logic [mgki_pkg::BYTE_BITS-1:0] b);
      logic                              prefix_seen;
      logic [mgki_pkg::GROUP_BITS-1:0]   n;
      logic [mgki_pkg::UNSAVED_BITS:0]   u;
      logic                              save;
      keyframe_type                      e;
      prefix_seen = (window == mgki_pkg::CODE_PREFIX);
      window = {window[mgki_pkg::WINDOW_BITS-9:0], b};
      if (prefix_seen) begin
         if (b == mgki_pkg::CODE_PACK) begin
            pack_offset = stream_offset - mgki_pkg::PACK_BACKSTEP;
         end else if (b == mgki_pkg::CODE_SEQ) begin
            seq_offset = pack_offset;
         end else if (b == mgki_pkg::CODE_GOP && seq_offset == pack_offset) begin
            e.frame_count = mgki_pkg::FRAME_BITS'(groups) *
                            mgki_pkg::FRAME_BITS'(gop_size);
            groups = groups + 1;
            n = groups;
            u = {1'b0, unsaved} + 1'b1;
            save = (n < mgki_pkg::EARLY_LIMIT && n % EARLY_PERIOD == 1) ||
                   u >= mgki_pkg::FLUSH_LIMIT;
            unsaved = save ? '0 : u[mgki_pkg::UNSAVED_BITS-1:0];
            e.gop_number    = n;
            e.pack_position = pack_offset;
            e.flush         = save;
            expected_keyframes.push_back(e);
         end
      end
      stream_offset = stream_offset + 1'b1;
   endfunction

   task report_mismatch(input string what);
      $display("MISMATCH: %s", what);
      errors++;
   endtask

   // Compare one accepted result beat with the oldest expectation
   task check_result(input keyframe_type got);
      keyframe_type e;
      if (expected_keyframes.size() == 0) begin
         report_mismatch($sformatf("unexpected result beat gop_number=%0d", got.gop_number));
      end else begin
         e = expected_keyframes.pop_front();
         if (got.gop_number !== e.gop_number)
            report_mismatch($sformatf("gop_number got %0d exp %0d",
                                      got.gop_number, e.gop_number));
         if (got.pack_position !== e.pack_position)
            report_mismatch($sformatf("gop %0d pack_position got %0d exp %0d",
                                      e.gop_number, got.pack_position, e.pack_position));
         if (got.frame_count !== e.frame_count)
            report_mismatch($sformatf("gop %0d frame_count got %0d exp %0d",
                                      e.gop_number, got.frame_count, e.frame_count));
         if (got.flush !== e.flush)
            report_mismatch($sformatf("gop %0d flush got %0b exp %0b",
                                      e.gop_number, got.flush, e.flush));
      end
   endtask
endclass

module tb_mpeg_gop_keyframe_indexer;

   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BYTES  = 220;
   localparam int HOLD_CYCLES  = 200;
   localparam int BURST_GOPS   = 30;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [mgki_pkg::BYTE_BITS-1:0]      req_data_byte = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [mgki_pkg::GROUP_BITS-1:0]     rsp_gop_number;
   logic [mgki_pkg::POS_BITS-1:0]       rsp_pack_position;
   logic [mgki_pkg::FRAME_BITS-1:0]     rsp_frame_count;
   logic                                rsp_flush;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [mgki_pkg::GOP_SIZE_BITS-1:0]  csr_gop_size = '0;

   keyframe_scoreboard sb;
   logic [mgki_pkg::BYTE_BITS-1:0] stream_q[$];
   int idle_pct     = 0;
   int stall_pct    = 0;
   int hold_request = 0;
   int hold_left    = 0;
   logic hold_taken = 1'b0;

   mpeg_gop_keyframe_indexer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_gop_number    (rsp_gop_number),
      .rsp_pack_position (rsp_pack_position),
      .rsp_frame_count   (rsp_frame_count),
      .rsp_flush         (rsp_flush),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_gop_size      (csr_gop_size)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit
   initial begin
      #(20 * 400000);
      $display("mpeg_gop_keyframe_indexer test failed");
      $finish;
   end

   // Receiver: random stalls, or a long hold-off once requested
   always @(negedge clock) begin
      if (hold_request != 0 && !hold_taken) begin
         hold_left  = hold_request;
         hold_taken = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_gop_number, rsp_pack_position, rsp_frame_count, rsp_flush});
   end

   // Offer one byte, with random idle cycles ahead of it
   task automatic send_byte(input logic [mgki_pkg::BYTE_BITS-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b);
   endtask

   task automatic send_stream();
      foreach (stream_q[i]) send_byte(stream_q[i]);
      stream_q.delete();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic push_code(input logic [mgki_pkg::BYTE_BITS-1:0] code);
      stream_q.push_back(mgki_pkg::CODE_PREFIX[23:16]);
      stream_q.push_back(mgki_pkg::CODE_PREFIX[15:8]);
      stream_q.push_back(mgki_pkg::CODE_PREFIX[7:0]);
      stream_q.push_back(code);
   endtask

   // Noise with plenty of zero bytes so that stray prefixes turn up
   task automatic push_noise(input int n);
      repeat (n)
         stream_q.push_back(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255)));
   endtask

   // One random stretch of stream: mostly well-formed headers, some broken
   task automatic push_segment();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         push_code(mgki_pkg::CODE_PACK);
         push_noise($urandom_range(4));
      end else if (pick < 25) begin
         push_code(mgki_pkg::CODE_SEQ);
         push_noise($urandom_range(4));
      end else if (pick < 70) begin
         push_code(mgki_pkg::CODE_GOP);
         push_noise($urandom_range(2));
      end else if (pick < 78) begin
         // prefix with an arbitrary code
         push_code(8'($urandom_range(255)));
      end else if (pick < 84) begin
         // short or damaged prefix ahead of a GOP code
         stream_q.push_back(mgki_pkg::CODE_PREFIX[15:8]);
         stream_q.push_back(($urandom_range(1) == 0) ? mgki_pkg::CODE_PREFIX[7:0] : 8'h02);
         stream_q.push_back(mgki_pkg::CODE_GOP);
      end else begin
         push_noise($urandom_range(1, 8));
      end
   endtask

   task automatic wait_idle();
      while (sb.expected_keyframes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_gop_size(input logic [mgki_pkg::GOP_SIZE_BITS-1:0] v);
      @(negedge clock);
      csr_valid    <= 1'b1;
      csr_gop_size <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_gop_size(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input logic [mgki_pkg::GOP_SIZE_BITS-1:0] gs,
                               input int send_idle, input int recv_stall);
      wait_idle();
      write_gop_size(gs);
      idle_pct  = send_idle;
      stall_pct = recv_stall;
      while (stream_q.size() < PHASE_BYTES) push_segment();
      send_stream();
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: GOP before any header, pack, orphan GOP, sequence, GOP
      // behind an extra leading zero, and the byte extremes
      push_code(mgki_pkg::CODE_GOP);
      push_code(mgki_pkg::CODE_PACK);
      push_code(mgki_pkg::CODE_GOP);
      push_code(mgki_pkg::CODE_SEQ);
      stream_q.push_back(8'h00);
      push_code(mgki_pkg::CODE_GOP);
      stream_q.push_back(8'hFF);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'hFF);
      send_stream();

      // Random phases over gop_size extremes, idling and stall patterns
      random_phase(8'd255, 0, 0);
      random_phase(8'd1, 67, 0);
      random_phase(8'd0, 0, 67);
      random_phase(8'($urandom_range(2, 254)), 19, 19);

      // Back pressure: long receiver hold-off against a burst of keyframes
      wait_idle();
      write_gop_size(8'($urandom_range(1, 255)));
      idle_pct  = 0;
      stall_pct = 0;
      push_code(mgki_pkg::CODE_PACK);
      push_code(mgki_pkg::CODE_SEQ);
      repeat (BURST_GOPS) push_code(mgki_pkg::CODE_GOP);
      hold_request = HOLD_CYCLES;
      send_stream();
      stall_pct = 30;
      while (stream_q.size() < PHASE_BYTES / 2) push_segment();
      send_stream();

      wait_idle();
      if (sb.expected_keyframes.size() != 0)
         sb.report_mismatch($sformatf("%0d keyframe beats never arrived",
                                      sb.expected_keyframes.size()));
      if (sb.errors == 0) begin
         $display("mpeg_gop_keyframe_indexer test passed");
      end else begin
         $display("mpeg_gop_keyframe_indexer test failed");
      end
      $finish;
   end

endmodule
